/* sv/mmt_pkg.sv */
// mmt_pkg: shared types and codes for the A times B-transposed matrix block.
// Used by mmt_front, mmt_queue, mmt_back and matrix_multiply_transposed_core.
// No dependencies.
package mmt_pkg;

  // Input item modes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_A_ROWS    = 2'd0;
  localparam logic [1:0] REG_B_ROWS    = 2'd1;
  localparam logic [1:0] REG_INNER_LEN = 2'd2;

  localparam int CFG_DW = 5;
  localparam int CFG_IW = 2;

  // Work kinds after classification
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [35:0] product;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] a_rows;
    logic [3:0] b_rows;
    logic [4:0] inner_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [3:0]  col;
    logic [15:0] value;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/mmt_front.sv */
// mmt_front: accepts input items and sorts them into queue commands.
// Depends on mmt_pkg. Drops mode 3 items and out-of-range writes.
module mmt_front #(
  parameter int MAX_A_ROWS = 8,
  parameter int MAX_B_ROWS = 8,
  parameter int MAX_INNER  = 16
) (
  input  logic              start,
  output logic              busy,
  input  mmt_pkg::in_item_t in_item,
  input  mmt_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output mmt_pkg::q_entry_t q_wdata
);

  logic accept;
  logic keep;
  logic a_ok;
  logic b_ok;
  logic col_ok;

  // Hold off new items only when the queue has no room
  assign busy   = q_stat.full;
  assign accept = start && !q_stat.full;

  assign col_ok = 32'(in_item.col) < MAX_INNER;
  assign a_ok   = (32'(in_item.row) < MAX_A_ROWS) && col_ok;
  assign b_ok   = (32'(in_item.row) < MAX_B_ROWS) && col_ok;

  // Classify the item
  always_comb begin
    keep          = 1'b0;
    q_wdata.kind  = mmt_pkg::KIND_COMPUTE;
    q_wdata.row   = in_item.row;
    q_wdata.col   = in_item.col;
    q_wdata.value = in_item.value;
    case (in_item.mode)
      mmt_pkg::MODE_LOAD_A: begin
        keep         = a_ok;
        q_wdata.kind = mmt_pkg::KIND_LOAD_A;
      end
      mmt_pkg::MODE_LOAD_B: begin
        keep         = b_ok;
        q_wdata.kind = mmt_pkg::KIND_LOAD_B;
      end
      mmt_pkg::MODE_COMPUTE: begin
        keep         = 1'b1;
        q_wdata.kind = mmt_pkg::KIND_COMPUTE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

/* sv/mmt_queue.sv */
// mmt_queue: small in-order command queue between front and back.
// Depends on mmt_pkg for the entry type and depth.
module mmt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmt_pkg::q_entry_t wdata,
  input  logic              pop,
  output mmt_pkg::q_entry_t rdata,
  output mmt_pkg::q_stat_t  stat
);

  mmt_pkg::q_entry_t           slot_r [mmt_pkg::Q_DEPTH];
  logic [mmt_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [mmt_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [mmt_pkg::Q_CW-1:0]    count_r;

  assign rdata      = slot_r[rd_ptr_r];
  assign stat.full  = count_r == mmt_pkg::Q_CW'(mmt_pkg::Q_DEPTH);
  assign stat.empty = count_r == '0;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

/* sv/mmt_back.sv */
// mmt_back: executes queued commands: element writes into the A and B stores,
// and the compute sequencer with read, multiply and accumulate stages.
// Depends on mmt_pkg.
module mmt_back #(
  parameter int MAX_A_ROWS = 8,
  parameter int MAX_B_ROWS = 8,
  parameter int MAX_INNER  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mmt_pkg::cfg_t      cfg,
  input  mmt_pkg::q_entry_t  q_rdata,
  input  mmt_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_valid,
  output mmt_pkg::out_item_t out_item
);

  localparam int AIW   = (MAX_A_ROWS > 1) ? $clog2(MAX_A_ROWS) : 1;
  localparam int BIW   = (MAX_B_ROWS > 1) ? $clog2(MAX_B_ROWS) : 1;
  localparam int KW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int A_DEP = MAX_A_ROWS * MAX_INNER;
  localparam int B_DEP = MAX_B_ROWS * MAX_INNER;
  localparam int AAW   = (A_DEP > 1) ? $clog2(A_DEP) : 1;
  localparam int BAW   = (B_DEP > 1) ? $clog2(B_DEP) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic st_r, st_nxt;
  logic [AIW-1:0] i_r, i_nxt, i_last_r, i_last_nxt;
  logic [BIW-1:0] j_r, j_nxt, j_last_r, j_last_nxt;
  logic [KW-1:0]  k_r, k_nxt, k_last_r, k_last_nxt;

  logic k_end, j_end, i_end;
  logic issue;
  logic we_a, we_b;
  logic [AAW-1:0] wa_addr, ra_addr;
  logic [BAW-1:0] wb_addr, rb_addr;

  logic [15:0] mem_a [A_DEP];
  logic [15:0] mem_b [B_DEP];
  logic [15:0] rd_a_r, rd_b_r;

  // Stage 1: read data tags
  logic       s1_v_r, s1_first_r, s1_lastk_r, s1_last_r;
  logic [2:0] s1_row_r, s1_col_r;
  // Stage 2: product and tags
  logic              s2_v_r, s2_first_r, s2_lastk_r, s2_last_r;
  logic [2:0]        s2_row_r, s2_col_r;
  logic signed [31:0] s2_prod_r;
  // Stage 3: accumulator
  logic signed [35:0] acc_r, acc_sum;
  logic               out_valid_r;
  mmt_pkg::out_item_t out_item_r;

  assign k_end = k_r == k_last_r;
  assign j_end = j_r == j_last_r;
  assign i_end = i_r == i_last_r;
  assign issue = st_r == ST_RUN;
  assign q_pop = (st_r == ST_IDLE) && !q_stat.empty;

  // Counts saturated to their legal range, as last indexes
  always_comb begin
    if (cfg.a_rows == '0)                 i_last_nxt = '0;
    else if (32'(cfg.a_rows) > MAX_A_ROWS) i_last_nxt = AIW'(MAX_A_ROWS - 1);
    else                                   i_last_nxt = AIW'(cfg.a_rows - 4'd1);
    if (cfg.b_rows == '0)                 j_last_nxt = '0;
    else if (32'(cfg.b_rows) > MAX_B_ROWS) j_last_nxt = BIW'(MAX_B_ROWS - 1);
    else                                   j_last_nxt = BIW'(cfg.b_rows - 4'd1);
    if (cfg.inner_len == '0)                k_last_nxt = '0;
    else if (32'(cfg.inner_len) > MAX_INNER) k_last_nxt = KW'(MAX_INNER - 1);
    else                                     k_last_nxt = KW'(cfg.inner_len - 5'd1);
  end

  // Sequencer: pop a command, or step through i, j, k while computing
  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    j_nxt  = j_r;
    k_nxt  = k_r;
    if (q_pop && q_rdata.kind == mmt_pkg::KIND_COMPUTE) begin
      st_nxt = ST_RUN;
      i_nxt  = '0;
      j_nxt  = '0;
      k_nxt  = '0;
    end else if (issue) begin
      if (!k_end) begin
        k_nxt = k_r + 1'b1;
      end else begin
        k_nxt = '0;
        if (!j_end) begin
          j_nxt = j_r + 1'b1;
        end else begin
          j_nxt = '0;
          if (!i_end) i_nxt = i_r + 1'b1;
          else        st_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      i_r  <= '0;
      j_r  <= '0;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
      k_r  <= k_nxt;
    end
  end

  // Limits are taken when the compute command starts
  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.kind == mmt_pkg::KIND_COMPUTE) begin
      i_last_r <= i_last_nxt;
      j_last_r <= j_last_nxt;
      k_last_r <= k_last_nxt;
    end
  end

  // Store addresses: element (r, c) at r * MAX_INNER + c
  assign we_a    = q_pop && q_rdata.kind == mmt_pkg::KIND_LOAD_A;
  assign we_b    = q_pop && q_rdata.kind == mmt_pkg::KIND_LOAD_B;
  assign wa_addr = AAW'(32'(q_rdata.row) * MAX_INNER + 32'(q_rdata.col));
  assign wb_addr = BAW'(32'(q_rdata.row) * MAX_INNER + 32'(q_rdata.col));
  assign ra_addr = AAW'(32'(i_r) * MAX_INNER + 32'(k_r));
  assign rb_addr = BAW'(32'(j_r) * MAX_INNER + 32'(k_r));

  // A store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa_addr] <= q_rdata.value;
    rd_a_r <= mem_a[ra_addr];
  end

  // B store
  always_ff @(posedge clk) begin
    if (we_b) mem_b[wb_addr] <= q_rdata.value;
    rd_b_r <= mem_b[rb_addr];
  end

  // Stage 1 tags travel alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= issue;
  end

  always_ff @(posedge clk) begin
    s1_first_r <= k_r == '0;
    s1_lastk_r <= k_end;
    s1_last_r  <= i_end && j_end;
    s1_row_r   <= 3'(i_r);
    s1_col_r   <= 3'(j_r);
  end

  // Stage 2: Q8.8 by Q8.8 product, exact Q16.16
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_prod_r  <= $signed(rd_a_r) * $signed(rd_b_r);
    s2_first_r <= s1_first_r;
    s2_lastk_r <= s1_lastk_r;
    s2_last_r  <= s1_last_r;
    s2_row_r   <= s1_row_r;
    s2_col_r   <= s1_col_r;
  end

  // Stage 3: accumulate, wrapping at 36 bits
  assign acc_sum = (s2_first_r ? 36'sd0 : acc_r) +
                   {{4{s2_prod_r[31]}}, s2_prod_r};

  always_ff @(posedge clk) begin
    if (s2_v_r) acc_r <= acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s2_v_r && s2_lastk_r;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_lastk_r) begin
      out_item_r.product <= acc_sum;
      out_item_r.out_row <= s2_row_r;
      out_item_r.out_col <= s2_col_r;
      out_item_r.last    <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/matrix_multiply_transposed_core.sv */
// matrix_multiply_transposed_core: top level of the C = A times B-transposed block.
// Depends on mmt_pkg, mmt_front, mmt_queue and mmt_back.
//
// Usage:
//   Input channel: an item is taken at a clock edge with start high and busy
//   low. Mode 0 writes one A element, mode 1 one B element (row, col, value),
//   mode 2 computes. Mode 3 and writes outside the stores are dropped.
//   Items pass through a 4-entry command queue; busy is high while it is full.
//   Load items drain at one per cycle while no compute runs, so a stream of
//   loads runs at one item per clock. A compute item holds the back end until
//   it has stepped through all a_rows * b_rows * inner_len dot product terms
//   (one per cycle, set by the single read port of each store and the one
//   multiplier); loads behind it wait in the queue. Each C element strobes
//   once its last term has been accumulated.
//   Result channel: out_valid strobes for one cycle per C element, in
//   row-major order; out_item.last marks the final element. The receiver
//   cannot stall, and none is needed.
//   Configuration: cfg_we writes register cfg_index (0 a_rows, 1 b_rows,
//   2 inner_len); the user must write only while the block is idle (not enforced).
//   Reset (synchronous, rst_n low) empties the queue, stops any compute and
//   restores the counts to 8, 8, 16. Store contents are undefined until written.
module matrix_multiply_transposed_core #(
  parameter int MAX_A_ROWS = 8,
  parameter int MAX_B_ROWS = 8,
  parameter int MAX_INNER  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mmt_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output mmt_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [mmt_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mmt_pkg::CFG_DW-1:0]    cfg_wdata
);

  mmt_pkg::cfg_t     cfg_r;
  mmt_pkg::q_entry_t q_wdata;
  mmt_pkg::q_entry_t q_rdata;
  mmt_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows    <= 4'd8;
      cfg_r.b_rows    <= 4'd8;
      cfg_r.inner_len <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        mmt_pkg::REG_A_ROWS:    cfg_r.a_rows    <= cfg_wdata[3:0];
        mmt_pkg::REG_B_ROWS:    cfg_r.b_rows    <= cfg_wdata[3:0];
        mmt_pkg::REG_INNER_LEN: cfg_r.inner_len <= cfg_wdata;
        default:                cfg_r           <= cfg_r;
      endcase
    end
  end

  mmt_front #(
    .MAX_A_ROWS (MAX_A_ROWS),
    .MAX_B_ROWS (MAX_B_ROWS),
    .MAX_INNER  (MAX_INNER)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  mmt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mmt_back #(
    .MAX_A_ROWS (MAX_A_ROWS),
    .MAX_B_ROWS (MAX_B_ROWS),
    .MAX_INNER  (MAX_INNER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Back end never takes a command from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // A result right after a run's last element starts a new run at (0, 0)
  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=>
      (!out_valid || (out_item.out_row == 3'd0 && out_item.out_col == 3'd0)))
    else $error("run did not restart at the first element");

  // No result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

/* test/mmt_product_checker.sv */
`timescale 1ns / 100ps
// mmt_product_checker: watches the item, result and register ports of the matrix block,
// predicts every C element of A times B-transposed and compares the strobed results.
// Depends on mmt_pkg only.
module mmt_product_checker #(
  parameter int MAX_A_ROWS = 8,
  parameter int MAX_B_ROWS = 8,
  parameter int MAX_INNER  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  mmt_pkg::in_item_t           in_item,
  input  logic                        out_valid,
  input  mmt_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [mmt_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [mmt_pkg::CFG_DW-1:0]  cfg_wdata,
  output int                          n_fail,
  output int                          n_pending,
  output int                          n_results
);

  // shadow copies of both element stores and the raw count registers
  logic signed [15:0] a_elems [MAX_A_ROWS][MAX_INNER];
  logic signed [15:0] b_elems [MAX_B_ROWS][MAX_INNER];
  logic [3:0]         a_rows_raw;
  logic [3:0]         b_rows_raw;
  logic [4:0]         inner_raw;

  mmt_pkg::out_item_t c_expected [$];
  mmt_pkg::out_item_t want;
  int                 errs = 0;
  int                 seen = 0;

  initial begin
    n_fail    = 0;
    n_pending = 0;
    n_results = 0;
  end

  // zero means one, anything past the store size means the store size
  function automatic int used_count(int raw, int hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // queue every element of C, row-major, each an exact Q20.16 dot product
  function automatic void predict_c_matrix();
    int                 na;
    int                 nb;
    int                 nk;
    longint             sum;
    mmt_pkg::out_item_t c;
    na = used_count(a_rows_raw, MAX_A_ROWS);
    nb = used_count(b_rows_raw, MAX_B_ROWS);
    nk = used_count(inner_raw, MAX_INNER);
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < nb; j++) begin
        sum = 0;
        for (int k = 0; k < nk; k++)
          sum += longint'(a_elems[i][k]) * longint'(b_elems[j][k]);
        c.product = sum[35:0];
        c.out_row = 3'(i);
        c.out_col = 3'(j);
        c.last    = (i == na - 1) && (j == nb - 1);
        c_expected.push_back(c);
      end
    end
  endfunction

  task automatic note_mismatch(string field, longint exp_val, longint act_val);
    errs++;
    $display("%0t: C[%0d][%0d] %s expected %0d got %0d", $time,
             want.out_row, want.out_col, field, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      a_rows_raw = 4'd8;
      b_rows_raw = 4'd8;
      inner_raw  = 5'd16;
      c_expected.delete();
    end else begin
      // results first: one strobe, one comparison against the oldest expectation
      if (out_valid) begin
        seen++;
        if (c_expected.size() == 0) begin
          errs++;
          $display("%0t: C[%0d][%0d] expected nothing got %0d", $time,
                   out_item.out_row, out_item.out_col, out_item.product);
        end else begin
          want = c_expected.pop_front();
          if (out_item.product !== want.product)
            note_mismatch("product", longint'(want.product), longint'(out_item.product));
          if (out_item.out_row !== want.out_row)
            note_mismatch("row", want.out_row, out_item.out_row);
          if (out_item.out_col !== want.out_col)
            note_mismatch("col", want.out_col, out_item.out_col);
          if (out_item.last !== want.last)
            note_mismatch("last", want.last, out_item.last);
        end
      end

      // register writes; unknown indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          mmt_pkg::REG_A_ROWS:    a_rows_raw = cfg_wdata[3:0];
          mmt_pkg::REG_B_ROWS:    b_rows_raw = cfg_wdata[3:0];
          mmt_pkg::REG_INNER_LEN: inner_raw  = cfg_wdata;
          default: ;
        endcase
      end

      // accepted item
      if (start && !busy) begin
        case (in_item.mode)
          mmt_pkg::MODE_LOAD_A:
            if (in_item.row < MAX_A_ROWS && in_item.col < MAX_INNER)
              a_elems[in_item.row][in_item.col] = in_item.value;
          mmt_pkg::MODE_LOAD_B:
            if (in_item.row < MAX_B_ROWS && in_item.col < MAX_INNER)
              b_elems[in_item.row][in_item.col] = in_item.value;
          mmt_pkg::MODE_COMPUTE:
            predict_c_matrix();
          default: ;
        endcase
      end
    end
    n_fail    <= errs;
    n_pending <= c_expected.size();
    n_results <= seen;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: drives matrix_multiply_transposed_core with directed corner items and then
// phases of random loads and computes under many count settings; gives the verdict.
// Depends on mmt_pkg, matrix_multiply_transposed_core and mmt_product_checker.
module tb_top;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int MAX_A        = 8;
  localparam int MAX_B        = 8;
  localparam int MAX_K        = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 1000000;

  typedef enum int {MIXED, ALL_MIN, MIN_TIMES_MAX} fill_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  mmt_pkg::in_item_t          in_item = '0;
  logic                       out_valid;
  mmt_pkg::out_item_t         out_item;
  logic                       cfg_we = 1'b0;
  logic [mmt_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [mmt_pkg::CFG_DW-1:0] cfg_wdata = '0;
  int                         n_fail;
  int                         n_pending;
  int                         n_results;

  // stimulus bookkeeping: which elements hold a value, and the raw counts
  bit          a_loaded [MAX_A][MAX_K];
  bit          b_loaded [MAX_B][MAX_K];
  int          a_raw = 8;
  int          b_raw = 8;
  int          k_raw = 16;
  fill_style_t fill_style = MIXED;
  bit          no_gaps = 1'b0;
  int          n_items = 0;
  int          n_computes = 0;
  int          n_settings = 0;
  longint      cycles = 0;

  always #10 clk = ~clk;

  matrix_multiply_transposed_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mmt_product_checker #(
    .MAX_A_ROWS (MAX_A),
    .MAX_B_ROWS (MAX_B),
    .MAX_INNER  (MAX_K)
  ) product_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_results (n_results)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int used_count(int raw, int hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // mostly back-to-back, some short pauses, a few long ones
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] element_value(bit for_b);
    case (fill_style)
      ALL_MIN:       return 16'h8000;
      MIN_TIMES_MAX: return for_b ? 16'h7FFF : 16'h8000;
      default: begin
        if ($urandom_range(0, 4) != 0) return 16'($urandom);
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          4:       return 16'h0001;
          default: return 16'h0100;
        endcase
      end
    endcase
  endfunction

  // start stays high between back-to-back items; lowered only for a gap
  task automatic issue(logic [1:0] mode, logic [2:0] row, logic [3:0] col,
                       logic [15:0] value);
    mmt_pkg::in_item_t it;
    int                gap;
    it.mode  = mode;
    it.row   = row;
    it.col   = col;
    it.value = value;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (mode == mmt_pkg::MODE_LOAD_A) a_loaded[row][col] = 1'b1;
    if (mode == mmt_pkg::MODE_LOAD_B) b_loaded[row][col] = 1'b1;
    n_items++;
  endtask

  // a compute never reads an element that was not loaded
  task automatic load_missing();
    for (int i = 0; i < used_count(a_raw, MAX_A); i++)
      for (int k = 0; k < used_count(k_raw, MAX_K); k++)
        if (!a_loaded[i][k])
          issue(mmt_pkg::MODE_LOAD_A, 3'(i), 4'(k), element_value(1'b0));
    for (int j = 0; j < used_count(b_raw, MAX_B); j++)
      for (int k = 0; k < used_count(k_raw, MAX_K); k++)
        if (!b_loaded[j][k])
          issue(mmt_pkg::MODE_LOAD_B, 3'(j), 4'(k), element_value(1'b1));
  endtask

  task automatic compute();
    load_missing();
    issue(mmt_pkg::MODE_COMPUTE, 3'($urandom), 4'($urandom), 16'($urandom));
    n_computes++;
  endtask

  // all results in, then time for queued loads to drain
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all three counts plus one write to the unused index
  task automatic set_counts(int a, int b, int k);
    logic [mmt_pkg::CFG_IW-1:0] idx [4];
    logic [mmt_pkg::CFG_DW-1:0] dat [4];
    idx = '{mmt_pkg::REG_A_ROWS, mmt_pkg::REG_B_ROWS, mmt_pkg::REG_INNER_LEN, REG_UNUSED};
    dat = '{{1'($urandom), 4'(a)}, {1'($urandom), 4'(b)}, 5'(k), 5'($urandom)};
    for (int n = 0; n < 4; n++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[n];
      cfg_wdata <= dat[n];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    a_raw = a & 15;
    b_raw = b & 15;
    k_raw = k & 31;
    n_settings++;
  endtask

  task automatic run_phase(int a, int b, int k, int loads, fill_style_t sty, bit bursty);
    int done;
    int r;
    wait_idle();
    set_counts(a, b, k);
    fill_style = sty;
    no_gaps    = bursty;
    // forced-value phases reload everything they use
    if (sty != MIXED) begin
      a_loaded = '{default: 1'b0};
      b_loaded = '{default: 1'b0};
    end
    done = 0;
    while (done < loads) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        compute();
      end else if (r < 11) begin
        issue(MODE_IGNORED, 3'($urandom), 4'($urandom), 16'($urandom));
      end else if (r < 55) begin
        issue(mmt_pkg::MODE_LOAD_A, 3'($urandom), 4'($urandom), element_value(1'b0));
        done++;
      end else begin
        issue(mmt_pkg::MODE_LOAD_B, 3'($urandom), 4'($urandom), element_value(1'b1));
        done++;
      end
    end
    compute();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // directed corners on a 1x1x1 product
    set_counts(1, 1, 1);
    issue(mmt_pkg::MODE_LOAD_A, 3'd0, 4'd0, 16'h7FFF);
    issue(mmt_pkg::MODE_LOAD_B, 3'd0, 4'd0, 16'h7FFF);
    issue(mmt_pkg::MODE_COMPUTE, 3'd0, 4'd0, 16'h0000);      // max times max
    issue(mmt_pkg::MODE_LOAD_A, 3'd0, 4'd0, 16'h8000);
    issue(mmt_pkg::MODE_COMPUTE, 3'd0, 4'd0, 16'h0000);      // min times max
    issue(mmt_pkg::MODE_LOAD_B, 3'd0, 4'd0, 16'h8000);
    issue(mmt_pkg::MODE_COMPUTE, 3'd0, 4'd0, 16'h0000);      // min times min
    issue(mmt_pkg::MODE_LOAD_A, 3'd0, 4'd0, 16'h0000);
    issue(mmt_pkg::MODE_COMPUTE, 3'd0, 4'd0, 16'h0000);      // zero
    issue(mmt_pkg::MODE_LOAD_A, 3'd7, 4'd15, 16'hFFFF);      // far corner, outside use
    issue(mmt_pkg::MODE_LOAD_B, 3'd7, 4'd15, 16'h0001);
    issue(MODE_IGNORED, 3'd7, 4'd15, 16'hFFFF);              // dropped
    issue(MODE_IGNORED, 3'd0, 4'd0, 16'h0000);
    issue(mmt_pkg::MODE_LOAD_A, 3'd0, 4'd0, 16'hFFFF);
    issue(mmt_pkg::MODE_COMPUTE, 3'd7, 4'd15, 16'hFFFF);     // fields ignored on compute
    n_computes += 5;

    // full-length rows at the value extremes
    run_phase(1, 1, 16, 10, ALL_MIN, 1'b0);
    run_phase(1, 1, 16, 10, MIN_TIMES_MAX, 1'b1);
    // largest and smallest shapes, then clamped register values
    run_phase(8, 8, 16, 30, MIXED, 1'b0);
    run_phase(0, 0, 0, 10, MIXED, 1'b1);
    run_phase(15, 15, 31, 15, MIXED, 1'b0);
    run_phase(3, 5, 7, 20, MIXED, 1'b1);
    run_phase(8, 1, 1, 15, MIXED, 1'b0);
    run_phase(1, 8, 16, 15, MIXED, 1'b0);
    run_phase(2, 7, 17, 10, MIXED, 1'b0);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
                10, MIXED, bit'(p % 2));

    wait_idle();
    $display("%0d items sent (%0d computes) under %0d count settings;", n_items,
             n_computes, n_settings);
    $display("%0d C elements checked, %0d errors", n_results, n_fail);
    if (n_fail == 0 && n_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/mmt_pkg.sv
sv/mmt_front.sv
sv/mmt_queue.sv
sv/mmt_back.sv
sv/matrix_multiply_transposed_core.sv
test/mmt_product_checker.sv
test/tb_top.sv
